@@ src/ewpm_pkg.sv @@
// Shared types, constants and command/status bundles for the portfolio metrics core.
package ewpm_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_ASSETS      = 64;
    localparam int DEF_MAX_MEMBERS = 16;

    // Fixed field widths.
    localparam int VAL_W   = 32;
    localparam int VOL_W   = 31;
    localparam int CORR_W  = 18;
    localparam int IDX_W   = 6;
    localparam int RSUM_W  = 40;
    localparam int VSUM_W  = 64;
    localparam int DIV_W   = 64;

    // Correlation saturation limits, Q1.16.
    localparam logic signed [VAL_W-1:0] CORR_HI = 32'sd131071;
    localparam logic signed [VAL_W-1:0] CORR_LO = -32'sd131072;

    // First bit weight of the square root recurrence.
    localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;

    // Saturated volatility.
    localparam logic [VOL_W-1:0] VOL_SAT = {VOL_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_RET    = 2'd0,
        ACT_VOL    = 2'd1,
        ACT_CORR   = 2'd2,
        ACT_MEMBER = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_RETURN_MIN = 2'd0,
        REG_RETURN_MAX = 2'd1,
        REG_VOL_MIN    = 2'd2,
        REG_VOL_MAX    = 2'd3
    } cfg_reg_t;

    // Which covariance term a request reads.
    typedef enum logic [1:0] {
        TK_DIAG  = 2'd0,
        TK_E_ROW = 2'd1,
        TK_ROW_E = 2'd2
    } term_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_ROW,
        ST_LD_ROW,
        ST_DIAG,
        ST_PAIR,
        ST_DRAIN,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       table_we;
        logic       set_ovf;
        logic       rd_row;
        logic       ld_row;
        logic       term_go;
        term_kind_t term_kind;
        logic       clr_i;
        logic       inc_i;
        logic       append;
        logic       div_start;
        logic       div_sel_var;
        logic       cap_mean;
        logic       sqrt_start;
        logic       cap_vol;
        logic       vol_zero;
        logic       vol_sat;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    last;
        logic    full;
        logic    pair_done;
        logic    pipe_busy;
        logic    div_done;
        logic    sqrt_done;
        logic    var_pos;
        logic    var_big;
        logic    out_free;
    } status_t;

endpackage

@@ src/ewpm_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned 64-bit dividend.
module ewpm_div
    import ewpm_pkg::*;
#(
    parameter int DVW = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVW-1:0]   divisor,
    output logic             done,
    output logic [DIV_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg;
    logic [DVW-1:0]   rem_reg;
    logic [DVW-1:0]   d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVW:0]     rem_sh;
    logic             ge;
    logic [DVW:0]     rem_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[DIV_W-1]};
        ge       = rem_sh >= {1'b0, d_reg};
        rem_next = ge ? (rem_sh - {1'b0, d_reg}) : rem_sh;
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_W-2:0], ge};
            rem_reg <= rem_next[DVW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ src/ewpm_sqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
module ewpm_sqrt
    import ewpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [63:0]      radicand,
    output logic             done,
    output logic [VOL_W-1:0] root
);

    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        take;

    // Trial subtract for the current bit pair.
    always_comb
    begin
        trial = res_reg + bit_reg;
        take  = x_reg >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Working registers of the recurrence.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= SQRT_TOP;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[VOL_W-1:0];

endmodule

@@ src/ewpm_datapath.sv @@
// Datapath: tables, member list, covariance pipeline, accumulators, divider, root, outputs.
module ewpm_datapath
    import ewpm_pkg::*;
#(
    parameter int ASSETS      = DEF_ASSETS,
    parameter int MAX_MEMBERS = DEF_MAX_MEMBERS,
    localparam int CW         = $clog2(MAX_MEMBERS + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 sts,
    input  logic [1:0]              action,
    input  logic [IDX_W-1:0]        asset_row,
    input  logic [IDX_W-1:0]        asset_col,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    last_member,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VAL_W-1:0] mean_return,
    output logic [VOL_W-1:0]        volatility,
    output logic                    in_window,
    output logic [CW-1:0]           member_count,
    output logic                    status
);

    localparam int AW    = $clog2(ASSETS);
    localparam int CAW   = $clog2(ASSETS * ASSETS);
    localparam int LW    = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int DVW   = 2 * CW;
    localparam int RECIP = 4096 / ASSETS;

    // Wrap of the raw asset indices onto the table depth.
    logic [AW-1:0] row_wrap;
    logic [AW-1:0] col_wrap;

    generate
        if (ASSETS >= 64)
        begin : g_nowrap
            assign row_wrap = AW'(asset_row);
            assign col_wrap = AW'(asset_col);
        end
        else
        begin : g_wrap
            logic [18:0] rq_prod;
            logic [18:0] cq_prod;
            logic [6:0]  rq;
            logic [6:0]  cq;
            logic [13:0] rr;
            logic [13:0] cr;

            // Quotient by reciprocal is low by at most one; one correction step.
            always_comb
            begin
                rq_prod  = 19'(asset_row) * 19'(RECIP);
                cq_prod  = 19'(asset_col) * 19'(RECIP);
                rq       = 7'(rq_prod >> 12);
                cq       = 7'(cq_prod >> 12);
                rr       = 14'(asset_row) - 14'(rq) * 14'(ASSETS);
                cr       = 14'(asset_col) - 14'(cq) * 14'(ASSETS);
                if (rr >= 14'(ASSETS))
                begin
                    rr = rr - 14'(ASSETS);
                end
                if (cr >= 14'(ASSETS))
                begin
                    cr = cr - 14'(ASSETS);
                end
                row_wrap = AW'(rr);
                col_wrap = AW'(cr);
            end
        end
    endgenerate

    // Captured request.
    action_t                 action_reg;
    logic [AW-1:0]           row_reg;
    logic [AW-1:0]           col_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                    last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action_t'(action);
            row_reg    <= row_wrap;
            col_reg    <= col_wrap;
            val_reg    <= value;
            last_reg   <= last_member;
        end
    end

    // Configuration registers.
    logic signed [VAL_W-1:0] rmin_reg;
    logic signed [VAL_W-1:0] rmax_reg;
    logic [VOL_W-1:0]        vmin_reg;
    logic [VOL_W-1:0]        vmax_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmin_reg <= {1'b1, {(VAL_W-1){1'b0}}};
            rmax_reg <= {1'b0, {(VAL_W-1){1'b1}}};
            vmin_reg <= '0;
            vmax_reg <= VOL_SAT;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RETURN_MIN: rmin_reg <= cfg_data;
                REG_RETURN_MAX: rmax_reg <= cfg_data;
                REG_VOL_MIN:    vmin_reg <= cfg_data[VOL_W-1:0];
                REG_VOL_MAX:    vmax_reg <= cfg_data[VOL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Member list and walk index.
    logic [AW-1:0] list_reg [MAX_MEMBERS];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] i_reg;
    logic          ovf_reg;
    logic [AW-1:0] e_idx;

    assign e_idx = list_reg[i_reg[LW-1:0]];

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            list_reg[cnt_reg[LW-1:0]] <= row_reg;
        end
    end

    // Table addresses for the reads of one term, the correlation write address and the saturated write data.
    logic [AW-1:0]  vol_raddr;
    logic [CAW-1:0] corr_raddr;
    logic [CAW-1:0] corr_waddr;
    logic [CAW-1:0] row_base;
    logic [CAW-1:0] e_base;
    logic signed [CORR_W-1:0] corr_wdata;

    always_comb
    begin
        row_base   = CAW'(row_reg) * CAW'(ASSETS);
        e_base     = CAW'(e_idx) * CAW'(ASSETS);
        corr_waddr = row_base + CAW'(col_reg);
        vol_raddr  = row_reg;
        corr_raddr = row_base + CAW'(row_reg);
        case (cmd.term_kind)
            TK_E_ROW:
            begin
                vol_raddr  = e_idx;
                corr_raddr = e_base + CAW'(row_reg);
            end
            TK_ROW_E:
            begin
                vol_raddr  = e_idx;
                corr_raddr = row_base + CAW'(e_idx);
            end
            default:
            begin
                vol_raddr  = row_reg;
                corr_raddr = row_base + CAW'(row_reg);
            end
        endcase
        if (val_reg > CORR_HI)
        begin
            corr_wdata = CORR_HI[CORR_W-1:0];
        end
        else if (val_reg < CORR_LO)
        begin
            corr_wdata = CORR_LO[CORR_W-1:0];
        end
        else
        begin
            corr_wdata = val_reg[CORR_W-1:0];
        end
    end

    // Table memories with registered read data.
    logic signed [VAL_W-1:0]  ret_mem  [ASSETS];
    logic signed [VAL_W-1:0]  vol_mem  [ASSETS];
    logic signed [CORR_W-1:0] corr_mem [ASSETS * ASSETS];
    logic signed [VAL_W-1:0]  ret_rd;
    logic signed [VAL_W-1:0]  vol_rd;
    logic signed [CORR_W-1:0] corr_rd;

    always_ff @(posedge clk)
    begin
        if (cmd.table_we && action_reg == ACT_RET)
        begin
            ret_mem[row_reg] <= val_reg;
        end
        ret_rd <= ret_mem[row_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.table_we && action_reg == ACT_VOL)
        begin
            vol_mem[row_reg] <= val_reg;
        end
        vol_rd <= vol_mem[vol_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.table_we && action_reg == ACT_CORR)
        begin
            corr_mem[corr_waddr] <= corr_wdata;
        end
        corr_rd <= corr_mem[corr_raddr];
    end

    // Covariance term pipeline: read, vol product, correlation product, accumulate.
    logic                     s1_v_reg;
    logic                     s2_v_reg;
    logic                     s3_v_reg;
    logic signed [VAL_W-1:0]  vr_reg;
    logic signed [63:0]       p_reg;
    logic signed [CORR_W-1:0] c_reg;
    logic signed [63:0]       t_reg;
    logic signed [47:0]       p_hi;
    logic signed [65:0]       t_prod;
    logic signed [47:0]       t_hi;

    assign p_hi   = p_reg[63:16];
    assign t_prod = p_hi * c_reg;
    assign t_hi   = t_reg[63:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.term_go;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_row)
        begin
            vr_reg <= vol_rd;
        end
        if (s1_v_reg)
        begin
            p_reg <= vol_rd * vr_reg;
            c_reg <= corr_rd;
        end
        if (s2_v_reg)
        begin
            t_reg <= t_prod[63:0];
        end
    end

    // Accumulators, member count and walk index.
    logic signed [RSUM_W-1:0] rsum_reg;
    logic signed [VSUM_W-1:0] vsum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsum_reg <= '0;
            vsum_reg <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                rsum_reg <= '0;
                vsum_reg <= '0;
                cnt_reg  <= '0;
                ovf_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.ld_row)
                begin
                    rsum_reg <= rsum_reg + RSUM_W'(ret_rd);
                end
                if (s3_v_reg)
                begin
                    vsum_reg <= vsum_reg + VSUM_W'(t_hi);
                end
                if (cmd.append)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (cmd.set_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.clr_i)
            begin
                i_reg <= '0;
            end
            else if (cmd.inc_i)
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
    end

    // Shared divider for the mean and the variance.
    logic [RSUM_W-1:0] rsum_abs;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVW-1:0]    div_divisor;
    logic [DVW-1:0]    n_sq;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    always_comb
    begin
        rsum_abs = rsum_reg[RSUM_W-1] ? RSUM_W'(-rsum_reg) : RSUM_W'(rsum_reg);
        n_sq     = DVW'(cnt_reg) * DVW'(cnt_reg);
        if (cmd.div_sel_var)
        begin
            div_dividend = DIV_W'(vsum_reg);
            div_divisor  = n_sq;
        end
        else
        begin
            div_dividend = DIV_W'(rsum_abs);
            div_divisor  = DVW'(cnt_reg);
        end
    end

    ewpm_div #(
        .DVW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Square root of the variance scaled to Q16.16.
    logic             sqrt_done;
    logic [VOL_W-1:0] sqrt_root;

    ewpm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand ({div_quot[45:0], 16'd0}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Final results.
    logic signed [VAL_W-1:0] mean_reg;
    logic [VOL_W-1:0]        volr_reg;
    logic                    win;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_mean)
        begin
            mean_reg <= rsum_reg[RSUM_W-1] ? -div_quot[VAL_W-1:0] : div_quot[VAL_W-1:0];
        end
        if (cmd.vol_zero)
        begin
            volr_reg <= '0;
        end
        else if (cmd.vol_sat)
        begin
            volr_reg <= VOL_SAT;
        end
        else if (cmd.cap_vol)
        begin
            volr_reg <= sqrt_root;
        end
    end

    assign win = (mean_reg >= rmin_reg) && (mean_reg <= rmax_reg) &&
                 (volr_reg >= vmin_reg) && (volr_reg <= vmax_reg);

    // Output register.
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] o_mean_reg;
    logic [VOL_W-1:0]        o_vol_reg;
    logic                    o_win_reg;
    logic [CW-1:0]           o_cnt_reg;
    logic                    o_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_mean_reg   <= mean_reg;
            o_vol_reg    <= volr_reg;
            o_win_reg    <= win;
            o_cnt_reg    <= cnt_reg;
            o_status_reg <= ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mean_return  = o_mean_reg;
    assign volatility   = o_vol_reg;
    assign in_window    = o_win_reg;
    assign member_count = o_cnt_reg;
    assign status       = o_status_reg;

    // Status toward the controller.
    always_comb
    begin
        sts.action    = action_reg;
        sts.last      = last_reg;
        sts.full      = cnt_reg == CW'(MAX_MEMBERS);
        sts.pair_done = i_reg == cnt_reg;
        sts.pipe_busy = s1_v_reg || s2_v_reg || s3_v_reg;
        sts.div_done  = div_done;
        sts.sqrt_done = sqrt_done;
        sts.var_pos   = (vsum_reg != '0) && !vsum_reg[VSUM_W-1];
        sts.var_big   = div_quot[DIV_W-1:46] != '0;
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    // Checks.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_MEMBERS))
        else $error("member count beyond maximum");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote a pending result");

    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_valid_reg && cnt_reg == '0 && !ovf_reg))
        else $error("accumulators not cleared after result");

    a_append_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !(s1_v_reg || s2_v_reg || s3_v_reg))
        else $error("member appended while terms in flight");

endmodule

@@ src/ewpm_ctrl.sv @@
// Controller state machine sequencing loads, member terms and the final results.
module ewpm_ctrl
    import ewpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   half_reg;
    logic   half_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        half_next     = half_reg;
        cmd           = '0;
        cmd.term_kind = TK_DIAG;
        in_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.action == ACT_MEMBER)
                begin
                    if (sts.full)
                    begin
                        cmd.set_ovf = 1'b1;
                        state_next  = sts.last ? ST_MEAN_GO : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD_ROW;
                    end
                end
                else
                begin
                    cmd.table_we = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD_ROW:
            begin
                cmd.rd_row = 1'b1;
                state_next = ST_LD_ROW;
            end
            ST_LD_ROW:
            begin
                cmd.ld_row = 1'b1;
                state_next = ST_DIAG;
            end
            ST_DIAG:
            begin
                cmd.term_go   = 1'b1;
                cmd.term_kind = TK_DIAG;
                cmd.clr_i     = 1'b1;
                half_next     = 1'b0;
                state_next    = ST_PAIR;
            end
            ST_PAIR:
            begin
                // Two terms per earlier member, one for each index order.
                if (sts.pair_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.term_go   = 1'b1;
                    cmd.term_kind = half_reg ? TK_ROW_E : TK_E_ROW;
                    cmd.inc_i     = half_reg;
                    half_next     = !half_reg;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    cmd.append = 1'b1;
                    state_next = sts.last ? ST_MEAN_GO : ST_IDLE;
                end
            end
            ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_mean = 1'b1;
                    state_next   = ST_VAR_GO;
                end
            end
            ST_VAR_GO:
            begin
                cmd.div_sel_var = 1'b1;
                if (!sts.var_pos)
                begin
                    cmd.vol_zero = 1'b1;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_VAR_WAIT;
                end
            end
            ST_VAR_WAIT:
            begin
                cmd.div_sel_var = 1'b1;
                if (sts.div_done)
                begin
                    if (sts.var_big)
                    begin
                        cmd.vol_sat = 1'b1;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SQRT_GO;
                    end
                end
            end
            ST_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.cap_vol = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/equal_weight_portfolio_metrics_core.sv @@
// Top level of the equal-weight portfolio metrics core.
//
// Requests enter on in_valid/in_stall: loads of the return, volatility and
// correlation tables, or members of one portfolio. Configuration writes of the
// return and volatility windows use cfg_valid/cfg_ready and are always taken.
// Results leave on out_valid/out_stall, one for each member marked last.
// A load is captured, then written to its table. A member is read and loaded,
// then its terms are issued: the covariance pipeline reads one term per cycle
// through the single correlation table read port, and both index orders are read
// for every pair. For a last member a 64-step divider serves the mean and then the
// variance, and a 32-step square root follows.
// The result sits in an output register, so new requests are taken while it
// waits; a stalled receiver only holds the block when the next result is ready.
// Reset clears the sums, count and flags and opens the windows to full range; the
// tables and the member list hold nothing defined until loaded.
module equal_weight_portfolio_metrics_core
    import ewpm_pkg::*;
#(
    parameter int ASSETS      = DEF_ASSETS,
    parameter int MAX_MEMBERS = DEF_MAX_MEMBERS,
    localparam int CW         = $clog2(MAX_MEMBERS + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              action,
    input  logic [IDX_W-1:0]        asset_row,
    input  logic [IDX_W-1:0]        asset_col,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    last_member,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VAL_W-1:0] mean_return,
    output logic [VOL_W-1:0]        volatility,
    output logic                    in_window,
    output logic [CW-1:0]           member_count,
    output logic                    status
);

    cmd_t    cmd;
    status_t sts;

    ewpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ewpm_datapath #(
        .ASSETS      (ASSETS),
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .action       (action),
        .asset_row    (asset_row),
        .asset_col    (asset_col),
        .value        (value),
        .last_member  (last_member),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean_return  (mean_return),
        .volatility   (volatility),
        .in_window    (in_window),
        .member_count (member_count),
        .status       (status)
    );

endmodule

@@ test/tb_equal_weight_portfolio_metrics_core.sv @@
// Self-checking testbench for the equal-weight portfolio metrics core.
module tb_equal_weight_portfolio_metrics_core;
    import ewpm_pkg::*;

    localparam int N_ASSETS    = DEF_ASSETS;
    localparam int N_MEMBERS   = DEF_MAX_MEMBERS;
    localparam int RANDOM_REQS = 1150;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 300;
    localparam int HOLD_CYCLES = 600;

    // Expected content of one result.
    typedef struct {
        logic signed [VAL_W-1:0] mean;
        logic [VOL_W-1:0]        vol;
        logic                    win;
        logic [4:0]              cnt;
        logic                    ovf;
    } metrics_t;

    // Scoreboard: mirrors the tables, the running sums and the window registers.
    class portfolio_scoreboard;
        int             ret_tab [N_ASSETS];
        int             vol_tab [N_ASSETS];
        int             corr_tab[N_ASSETS*N_ASSETS];
        int unsigned    members [N_MEMBERS];
        longint         ret_sum;
        longint         var_sum;
        int unsigned    cnt;
        bit             ovf;
        longint         ret_lo;
        longint         ret_hi;
        longint         vol_lo;
        longint         vol_hi;
        metrics_t       expected_q[$];
        int             errors;
        int             results_seen;
        int             overflows_seen;

        function new();
            ret_sum = 0;
            var_sum = 0;
            cnt = 0;
            ovf = 0;
            ret_lo = -64'sd2147483648;
            ret_hi = 64'sd2147483647;
            vol_lo = 0;
            vol_hi = 64'sd2147483647;
            errors = 0;
            results_seen = 0;
            overflows_seen = 0;
        endfunction

        function void write_window(cfg_reg_t idx, logic [31:0] data);
            case (idx)
                REG_RETURN_MIN: ret_lo = longint'($signed(data));
                REG_RETURN_MAX: ret_hi = longint'($signed(data));
                REG_VOL_MIN:    vol_lo = longint'({33'd0, data[30:0]});
                REG_VOL_MAX:    vol_hi = longint'({33'd0, data[30:0]});
                default: ;
            endcase
        endfunction

        function longint cov_term(int unsigned a, int unsigned b);
            longint p;
            longint r;
            p = longint'(vol_tab[a]) * longint'(vol_tab[b]);
            p = p >>> 16;
            r = p * longint'(corr_tab[a*N_ASSETS + b]);
            return r >>> 16;
        endfunction

        function logic [63:0] root_floor(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] bitw;
            res = 0;
            bitw = SQRT_TOP;
            while (bitw > x)
                bitw = bitw >> 2;
            while (bitw != 0)
            begin
                if (x >= res + bitw)
                begin
                    x = x - (res + bitw);
                    res = (res >> 1) + bitw;
                end
                else
                    res = res >> 1;
                bitw = bitw >> 2;
            end
            return res;
        endfunction

        // Updates the mirror for one accepted request and queues any result.
        function void note_request(action_t act, int unsigned row, int unsigned col,
                                   logic signed [31:0] val, bit last);
            longint      v;
            longint      mean;
            logic [63:0] uvar;
            logic [63:0] vol;
            metrics_t    m;
            v = longint'(val);
            case (act)
                ACT_RET:  ret_tab[row] = val;
                ACT_VOL:  vol_tab[row] = val;
                ACT_CORR:
                begin
                    if (v > 131071) v = 131071;
                    if (v < -131072) v = -131072;
                    corr_tab[row*N_ASSETS + col] = int'(v);
                end
                default:
                begin
                    if (cnt >= N_MEMBERS)
                        ovf = 1;
                    else
                    begin
                        ret_sum += longint'(ret_tab[row]);
                        var_sum += cov_term(row, row);
                        for (int i = 0; i < cnt; i++)
                        begin
                            var_sum += cov_term(members[i], row);
                            var_sum += cov_term(row, members[i]);
                        end
                        members[cnt] = row;
                        cnt++;
                    end
                    if (last)
                    begin
                        mean = ret_sum / longint'(cnt);
                        if (var_sum <= 0)
                            vol = 0;
                        else
                        begin
                            uvar = 64'(var_sum) / 64'(cnt * cnt);
                            if (uvar >= (64'd1 << 46))
                                vol = 64'h7FFF_FFFF;
                            else
                                vol = root_floor(uvar << 16);
                        end
                        m.mean = mean[31:0];
                        m.vol  = vol[30:0];
                        m.win  = (mean >= ret_lo) && (mean <= ret_hi) &&
                                 (longint'(vol) >= vol_lo) && (longint'(vol) <= vol_hi);
                        m.cnt  = cnt[4:0];
                        m.ovf  = ovf;
                        expected_q.insert(expected_q.size(), m);
                        ret_sum = 0;
                        var_sum = 0;
                        cnt = 0;
                        ovf = 0;
                    end
                end
            endcase
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(logic signed [31:0] mean, logic [30:0] vol, logic win,
                                   logic [4:0] mcnt, logic st);
            metrics_t m;
            results_seen++;
            if (st) overflows_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
                return;
            end
            m = expected_q.pop_front();
            if (mean !== m.mean)
            begin
                $error("mean_return expected %0d actual %0d", m.mean, mean);
                errors++;
            end
            if (vol !== m.vol)
            begin
                $error("volatility expected %0d actual %0d", m.vol, vol);
                errors++;
            end
            if (win !== m.win)
            begin
                $error("in_window expected %0d actual %0d", m.win, win);
                errors++;
            end
            if (mcnt !== m.cnt)
            begin
                $error("member_count expected %0d actual %0d", m.cnt, mcnt);
                errors++;
            end
            if (st !== m.ovf)
            begin
                $error("status expected %0d actual %0d", m.ovf, st);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              action;
    logic [IDX_W-1:0]        asset_row;
    logic [IDX_W-1:0]        asset_col;
    logic signed [VAL_W-1:0] value;
    logic                    last_member;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_index;
    logic [VAL_W-1:0]        cfg_data;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [VAL_W-1:0] mean_return;
    logic [VOL_W-1:0]        volatility;
    logic                    in_window;
    logic [4:0]              member_count;
    logic                    status;

    portfolio_scoreboard sb;
    bit          idle_en;
    int          hold_req;
    int          hold_seen;
    int          hold_cnt;
    int          quiet_cycles;
    int          reqs_sent;
    int unsigned pool[8] = '{0, 63, 1, 62, 21, 42, 9, 54};

    equal_weight_portfolio_metrics_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .asset_row    (asset_row),
        .asset_col    (asset_col),
        .value        (value),
        .last_member  (last_member),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean_return  (mean_return),
        .volatility   (volatility),
        .in_window    (in_window),
        .member_count (member_count),
        .status       (status)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result side: check accepted results, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(mean_return, volatility, in_window, member_count, status);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_cnt = HOLD_CYCLES;
            end
            else if (hold_cnt > 0)
                hold_cnt--;
            out_stall <= (hold_cnt > 0) || (idle_en && $urandom_range(0, 99) < 24);
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("equal_weight_portfolio_metrics_core test failed");
            $finish;
        end
    end

    // Sends one request and waits until it is accepted.
    task automatic send_req(action_t act, int unsigned row, int unsigned col,
                            logic [31:0] val, bit last);
        while (idle_en && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        asset_row   <= row[5:0];
        asset_col   <= col[5:0];
        value       <= val;
        last_member <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(act, row, col, val, last);
        reqs_sent++;
    endtask

    // Waits until every expected result has come.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Writes one window register while the core is idle; the caller drops cfg_valid.
    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_window(idx, data);
    endtask

    task automatic set_windows(logic [31:0] rlo, logic [31:0] rhi,
                               logic [31:0] vlo, logic [31:0] vhi);
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_RETURN_MIN, rlo);
        write_reg(REG_RETURN_MAX, rhi);
        write_reg(REG_VOL_MIN, vlo);
        write_reg(REG_VOL_MAX, vhi);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_vol();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 32'h0004_0000);
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_corr();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return $urandom_range(0, 262143) - 131072;
    endfunction

    // Random loads anywhere in the tables; member assets stay inside the pool.
    task automatic random_load();
        int unsigned r;
        int unsigned c;
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
        case ($urandom_range(0, 2))
            0: send_req(ACT_RET, r, c, $urandom(), 1'($urandom_range(0, 1)));
            1: send_req(ACT_VOL, r, c, rand_vol(), 1'($urandom_range(0, 1)));
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    r = pool[$urandom_range(0, 7)];
                    c = pool[$urandom_range(0, 7)];
                end
                send_req(ACT_CORR, r, c, rand_corr(), 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic random_portfolio(int len);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                random_load();
            send_req(ACT_MEMBER, pool[$urandom_range(0, 7)], $urandom_range(0, 63),
                     $urandom(), k == len - 1);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_RET;
        asset_row = '0;
        asset_col = '0;
        value = '0;
        last_member = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_RETURN_MIN;
        cfg_data = '0;
        out_stall = 1'b0;
        idle_en = 1'b1;
        hold_req = 0;
        hold_seen = 0;
        hold_cnt = 0;
        quiet_cycles = 0;
        reqs_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every return and volatility entry and the pool correlations.
        for (int a = 0; a < N_ASSETS; a++)
        begin
            send_req(ACT_RET, a, 0, $urandom(), 0);
            send_req(ACT_VOL, a, 0, rand_vol(), 0);
        end
        foreach (pool[i])
            foreach (pool[j])
                send_req(ACT_CORR, pool[i], pool[j], rand_corr(), 0);

        // Directed: single member with extreme return and volatility.
        send_req(ACT_RET, 63, 0, 32'h7FFF_FFFF, 0);
        send_req(ACT_VOL, 63, 0, 32'h8000_0000, 0);
        send_req(ACT_CORR, 63, 63, 32'h7FFF_FFFF, 0);
        send_req(ACT_MEMBER, 63, 0, 0, 1);
        // Correlation saturation at both ends and a negative diagonal.
        send_req(ACT_CORR, 0, 63, 32'h8000_0000, 0);
        send_req(ACT_CORR, 63, 0, 32'sd131072, 0);
        send_req(ACT_RET, 0, 0, 32'h8000_0000, 0);
        send_req(ACT_VOL, 0, 0, 32'h7FFF_FFFF, 0);
        send_req(ACT_CORR, 0, 0, -32'sd131073, 0);
        send_req(ACT_MEMBER, 0, 63, 32'hFFFF_FFFF, 1);
        // Duplicate members, then a load in the middle of a portfolio.
        send_req(ACT_MEMBER, 21, 0, 0, 0);
        send_req(ACT_MEMBER, 21, 0, 0, 0);
        send_req(ACT_VOL, 42, 0, 32'h0001_0000, 1);
        send_req(ACT_MEMBER, 42, 0, 0, 1);
        send_req(ACT_MEMBER, 0, 0, 0, 0);
        send_req(ACT_MEMBER, 63, 0, 0, 1);
        // Too many members: the seventeenth is dropped but still ends the set.
        for (int k = 0; k < N_MEMBERS + 1; k++)
            send_req(ACT_MEMBER, pool[k % 8], 0, 0, k == N_MEMBERS);
        for (int k = 0; k < N_MEMBERS + 3; k++)
            send_req(ACT_MEMBER, pool[(k * 3) % 8], 0, 0, k == N_MEMBERS + 2);

        // Narrow windows at the extremes, then a moderate window.
        set_windows(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_portfolio(1);
        random_portfolio(3);
        set_windows(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        random_portfolio(2);
        set_windows(32'hFFF0_0000, 32'h0010_0000, 32'h0, 32'h0100_0000);
        random_portfolio(4);

        // Random part in several phases, with one quiet stretch and pressure.
        reqs_sent = 0;
        while (reqs_sent < RANDOM_REQS)
        begin
            idle_en = !(reqs_sent > 450 && reqs_sent < 700);
            if (reqs_sent > 200 && hold_req == 0)
                hold_req <= 1;
            if (reqs_sent > 800 && hold_req == 1)
            begin
                // The sender pauses here until every result is back.
                hold_req <= 2;
                set_windows($urandom(), $urandom(), $urandom(), $urandom());
            end
            if (reqs_sent > 1100 && hold_req == 2)
            begin
                hold_req <= 3;
                set_windows(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
            end
            if ($urandom_range(0, 9) < 3)
                random_load();
            else if (hold_cnt > 0)
                random_portfolio($urandom_range(1, 3));
            else
                random_portfolio($urandom_range(1, 18));
        end
        idle_en = 1'b1;
        wait_drain();
        repeat (SETTLE) @(posedge clk);

        $display("Covered table loads, %0d results (%0d with dropped members),",
                 sb.results_seen, sb.overflows_seen);
        $display("window settings at the extremes, and long output back-pressure.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("equal_weight_portfolio_metrics_core test passed");
        else
            $display("equal_weight_portfolio_metrics_core test failed");
        $finish;
    end

endmodule

@@ equal_weight_portfolio_metrics_core.f @@
src/ewpm_pkg.sv
src/ewpm_div.sv
src/ewpm_sqrt.sv
src/ewpm_datapath.sv
src/ewpm_ctrl.sv
src/equal_weight_portfolio_metrics_core.sv
test/tb_equal_weight_portfolio_metrics_core.sv
